[hw/rtl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants for the pressure sensor compensation pipeline
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = 64 / DIV_STEPS;
    localparam int FRONT_STAGES = 10;
    localparam int BACK_STAGES  = 5;

    localparam logic signed [26:0] FINE_OFFSET = 27'sd128000;
    localparam logic [20:0]        PRES_BASE   = 21'd1048576;
    localparam logic [11:0]        PRES_SCALE  = 12'd3125;

    typedef enum logic [2:0] {
        REG_TEMP_CAL  = 3'd0,
        REG_PRES_LOW  = 3'd1,
        REG_PRES_HIGH = 3'd2,
        REG_PRES_LAST = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               neg;
        logic               invalid;
        logic signed [15:0] tc;
    } psc_tag_t;

endpackage

[hw/rtl/psc_div.sv]
// ----------------------------------------------------------------------------
// psc_div
// pipelined unsigned restoring divider, 64-bit dividend by 31-bit divisor
// ----------------------------------------------------------------------------
module psc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [63:0]        in_dividend,
    input  logic [30:0]        in_divisor,
    input  psc_pkg::psc_tag_t  in_tag,
    output logic               out_valid,
    output logic [63:0]        out_quotient,
    output psc_pkg::psc_tag_t  out_tag
);
    import psc_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [63:0]           work_reg [DIV_STAGES];
    logic [30:0]           rem_reg  [DIV_STAGES];
    logic [30:0]           div_reg  [DIV_STAGES];
    psc_tag_t              tag_reg  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [63:0] work_in;
        logic [30:0] rem_in;
        logic [30:0] div_in;
        psc_tag_t    tag_in;
        logic        valid_in;
        logic [63:0] work_next;
        logic [30:0] rem_next;

        if (s == 0)
        begin : g_first
            assign work_in  = in_dividend;
            assign rem_in   = '0;
            assign div_in   = in_divisor;
            assign tag_in   = in_tag;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign work_in  = work_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign div_in   = div_reg[s-1];
            assign tag_in   = tag_reg[s-1];
            assign valid_in = valid_reg[s-1];
        end

        always_comb
        begin
            logic [31:0] trial;
            work_next = work_in;
            rem_next  = rem_in;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                trial     = {rem_next, work_next[63]};
                work_next = {work_next[62:0], 1'b0};
                if (trial >= {1'b0, div_in})
                begin
                    rem_next     = 31'(trial - {1'b0, div_in});
                    work_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = trial[30:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            work_reg[s] <= work_next;
            rem_reg[s]  <= rem_next;
            div_reg[s]  <= div_in;
            tag_reg[s]  <= tag_in;
        end
    end

    assign out_valid    = valid_reg[DIV_STAGES-1];
    assign out_quotient = work_reg[DIV_STAGES-1];
    assign out_tag      = tag_reg[DIV_STAGES-1];

endmodule

[hw/rtl/pressure_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// integer temperature and pressure compensation of a barometric sensor
// ----------------------------------------------------------------------------
// usage
//   a request is taken at each rising edge with start high and busy low;
//   busy stays low, so a request may be given in every cycle
//   raw_pressure and raw_temperature are sampled with the request
//   one result per request: done is high for exactly one cycle with
//   temperature_centidegrees, pressure_q24_8 and pressure_invalid
//   each result passes through the 32-stage pipeline (ten front stages,
//   sixteen divider stages of four quotient bits each, five back stages
//   and the output register); throughput one request per cycle
//   calibration is written on cfg_write with cfg_index 0..3; the user
//   must write it only while the pipeline holds no request, which the
//   block itself does not enforce; other indexes are ignored
//   reset clears the calibration and drops every request in flight
//   results cannot be held off: the receiver takes each one as it appears
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        raw_pressure,
    input  logic [19:0]        raw_temperature,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] temperature_centidegrees,
    output logic [31:0]        pressure_q24_8,
    output logic               pressure_invalid
);
    import psc_pkg::*;

    // calibration
    logic [47:0] tcal_reg;
    logic [63:0] pcal_low_reg;
    logic [63:0] pcal_high_reg;
    logic [15:0] pcal_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg      <= '0;
            pcal_low_reg  <= '0;
            pcal_high_reg <= '0;
            pcal_last_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TEMP_CAL:  tcal_reg      <= cfg_data[47:0];
                REG_PRES_LOW:  pcal_low_reg  <= cfg_data;
                REG_PRES_HIGH: pcal_high_reg <= cfg_data;
                REG_PRES_LAST: pcal_last_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] p8_w, p9_w;

    assign t1   = tcal_reg[15:0];
    assign t2   = tcal_reg[31:16];
    assign t3   = tcal_reg[47:32];
    assign p1   = pcal_low_reg[15:0];
    assign p2   = pcal_low_reg[31:16];
    assign p3   = pcal_low_reg[47:32];
    assign p4   = pcal_low_reg[63:48];
    assign p5   = pcal_high_reg[15:0];
    assign p6   = pcal_high_reg[31:16];
    assign p7   = pcal_high_reg[47:32];
    assign p8   = pcal_high_reg[63:48];
    assign p9   = pcal_last_reg;
    assign p8_w = p8;
    assign p9_w = p9;

    assign busy = 1'b0;

    // valid bits
    logic [FRONT_STAGES-1:0] fv_reg;
    logic [BACK_STAGES-1:0]  bv_reg;
    logic                    done_reg;
    logic                    div_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg   <= '0;
            bv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fv_reg   <= {fv_reg[FRONT_STAGES-2:0], start};
            bv_reg   <= {bv_reg[BACK_STAGES-2:0], div_valid};
            done_reg <= bv_reg[BACK_STAGES-1];
        end
    end

    // stage 1: temperature differences and first products
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [33:0] s1_a_next, s1_a_reg;
    logic signed [33:0] s1_sq_next, s1_sq_reg;
    logic [19:0]        s1_rawp_reg;

    assign d1 = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign d2 = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign s1_a_next  = d1 * t2;
    assign s1_sq_next = d2 * d2;

    // stage 2
    logic signed [22:0] s2_a_reg;
    logic signed [37:0] s2_mb_next, s2_mb_reg;
    logic [19:0]        s2_rawp_reg;

    assign s2_mb_next = $signed(s1_sq_reg[33:12]) * t3;

    // stage 3: fine temperature
    logic signed [25:0] s3_fine_next, s3_fine_reg;
    logic [19:0]        s3_rawp_reg;

    assign s3_fine_next = s2_a_reg + $signed(s2_mb_reg[37:14]);

    // stage 4: offset, square, linear terms, temperature output
    logic signed [26:0] v1;
    logic signed [53:0] s4_vv_next, s4_vv_reg;
    logic signed [42:0] s4_v1p5_next, s4_v1p5_reg;
    logic signed [42:0] s4_v1p2_next, s4_v1p2_reg;
    logic signed [28:0] t5;
    logic signed [20:0] ts;
    logic signed [15:0] s4_tc_next, s4_tc_reg;
    logic [20:0]        s4_p_reg;

    assign v1           = s3_fine_reg - FINE_OFFSET;
    assign s4_vv_next   = v1 * v1;
    assign s4_v1p5_next = v1 * p5;
    assign s4_v1p2_next = v1 * p2;
    assign t5           = (s3_fine_reg <<< 2) + s3_fine_reg + 29'sd128;
    assign ts           = t5[28:8];

    always_comb
    begin
        if (ts > 21'sd32767)
        begin
            s4_tc_next = 16'sh7fff;
        end
        else if (ts < -21'sd32768)
        begin
            s4_tc_next = 16'sh8000;
        end
        else
        begin
            s4_tc_next = ts[15:0];
        end
    end

    // stage 5: quadratic partial products
    logic signed [43:0] s5_m6lo_next, s5_m6lo_reg, s5_m6hi_next, s5_m6hi_reg;
    logic signed [43:0] s5_m3lo_next, s5_m3lo_reg, s5_m3hi_next, s5_m3hi_reg;
    logic signed [42:0] s5_v1p5_reg, s5_v1p2_reg;
    logic signed [15:0] s5_tc_reg;
    logic [20:0]        s5_p_reg;

    assign s5_m6lo_next = $signed({1'b0, s4_vv_reg[26:0]}) * p6;
    assign s5_m6hi_next = $signed({1'b0, s4_vv_reg[53:27]}) * p6;
    assign s5_m3lo_next = $signed({1'b0, s4_vv_reg[26:0]}) * p3;
    assign s5_m3hi_next = $signed({1'b0, s4_vv_reg[53:27]}) * p3;

    // stage 6: wrapped 64-bit sums
    logic signed [63:0] s6_v2_next, s6_v2_reg;
    logic signed [63:0] s6_w3_next, s6_w3_reg;
    logic signed [42:0] s6_v1p2_reg;
    logic signed [15:0] s6_tc_reg;
    logic [20:0]        s6_p_reg;

    assign s6_v2_next = s5_m6lo_reg + (s5_m6hi_reg <<< 27) + (s5_v1p5_reg <<< 17)
                      + (p4 <<< 35);
    assign s6_w3_next = s5_m3lo_reg + (s5_m3hi_reg <<< 27);

    // stage 7: divisor base and numerator base
    logic signed [63:0] s7_x_next;
    logic [63:0]        s7_x_reg;
    logic signed [63:0] s7_num_next;
    logic [63:0]        s7_num_reg;
    logic signed [15:0] s7_tc_reg;

    assign s7_x_next   = (s6_w3_reg >>> 8) + (s6_v1p2_reg <<< 12)
                       + 64'sh0000_8000_0000_0000;
    assign s7_num_next = $signed({12'b0, s6_p_reg, 31'b0}) - s6_v2_reg;

    // stage 8: scaling partial products
    logic [47:0]        s8_xlo_next, s8_xlo_reg;
    logic [31:0]        s8_xhi_next, s8_xhi_reg;
    logic [43:0]        s8_nlo_next, s8_nlo_reg;
    logic [31:0]        s8_nhi_next, s8_nhi_reg;
    logic signed [15:0] s8_tc_reg;

    assign s8_xlo_next = s7_x_reg[31:0] * p1;
    assign s8_xhi_next = s7_x_reg[63:32] * p1;
    assign s8_nlo_next = s7_num_reg[31:0] * PRES_SCALE;
    assign s8_nhi_next = s7_num_reg[63:32] * PRES_SCALE;

    // stage 9: divisor and numerator
    logic [63:0]        xsum;
    logic [30:0]        s9_v1c_reg;
    logic [63:0]        s9_num_next, s9_num_reg;
    logic signed [15:0] s9_tc_reg;

    assign xsum        = {16'b0, s8_xlo_reg} + {s8_xhi_reg, 32'b0};
    assign s9_num_next = {20'b0, s8_nlo_reg} + {s8_nhi_reg, 32'b0};

    // stage 10: magnitudes and signs
    logic [63:0] s10_ma_next, s10_ma_reg;
    logic [30:0] s10_mb_next, s10_mb_reg;
    psc_tag_t    s10_tag_next, s10_tag_reg;

    assign s10_ma_next = s9_num_reg[63] ? 64'd0 - s9_num_reg : s9_num_reg;
    assign s10_mb_next = s9_v1c_reg[30] ? 31'd0 - s9_v1c_reg : s9_v1c_reg;
    assign s10_tag_next.neg     = s9_num_reg[63] ^ s9_v1c_reg[30];
    assign s10_tag_next.invalid = (s9_v1c_reg == 31'd0);
    assign s10_tag_next.tc      = s9_tc_reg;

    always_ff @(posedge clk)
    begin
        s1_a_reg    <= s1_a_next;
        s1_sq_reg   <= s1_sq_next;
        s1_rawp_reg <= raw_pressure;

        s2_a_reg    <= s1_a_reg[33:11];
        s2_mb_reg   <= s2_mb_next;
        s2_rawp_reg <= s1_rawp_reg;

        s3_fine_reg <= s3_fine_next;
        s3_rawp_reg <= s2_rawp_reg;

        s4_vv_reg   <= s4_vv_next;
        s4_v1p5_reg <= s4_v1p5_next;
        s4_v1p2_reg <= s4_v1p2_next;
        s4_tc_reg   <= s4_tc_next;
        s4_p_reg    <= PRES_BASE - {1'b0, s3_rawp_reg};

        s5_m6lo_reg <= s5_m6lo_next;
        s5_m6hi_reg <= s5_m6hi_next;
        s5_m3lo_reg <= s5_m3lo_next;
        s5_m3hi_reg <= s5_m3hi_next;
        s5_v1p5_reg <= s4_v1p5_reg;
        s5_v1p2_reg <= s4_v1p2_reg;
        s5_tc_reg   <= s4_tc_reg;
        s5_p_reg    <= s4_p_reg;

        s6_v2_reg   <= s6_v2_next;
        s6_w3_reg   <= s6_w3_next;
        s6_v1p2_reg <= s5_v1p2_reg;
        s6_tc_reg   <= s5_tc_reg;
        s6_p_reg    <= s5_p_reg;

        s7_x_reg    <= s7_x_next;
        s7_num_reg  <= s7_num_next;
        s7_tc_reg   <= s6_tc_reg;

        s8_xlo_reg  <= s8_xlo_next;
        s8_xhi_reg  <= s8_xhi_next;
        s8_nlo_reg  <= s8_nlo_next;
        s8_nhi_reg  <= s8_nhi_next;
        s8_tc_reg   <= s7_tc_reg;

        s9_v1c_reg  <= xsum[63:33];
        s9_num_reg  <= s9_num_next;
        s9_tc_reg   <= s8_tc_reg;

        s10_ma_reg  <= s10_ma_next;
        s10_mb_reg  <= s10_mb_next;
        s10_tag_reg <= s10_tag_next;
    end

    // divider
    logic [63:0] div_quot;
    psc_tag_t    div_tag;

    psc_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (fv_reg[FRONT_STAGES-1]),
        .in_dividend  (s10_ma_reg),
        .in_divisor   (s10_mb_reg),
        .in_tag       (s10_tag_reg),
        .out_valid    (div_valid),
        .out_quotient (div_quot),
        .out_tag      (div_tag)
    );

    // back stage 1: signed quotient
    logic [63:0] b1_q_next, b1_q_reg;
    psc_tag_t    b1_tag_reg;

    assign b1_q_next = div_tag.neg ? 64'd0 - div_quot : div_quot;

    // back stage 2: square and p8 partial products
    logic signed [63:0] hs;
    logic [63:0]        b2_aa_next, b2_aa_reg;
    logic [31:0]        b2_ab_next, b2_ab_reg;
    logic signed [48:0] b2_fl_next, b2_fl_reg;
    logic [31:0]        b2_fh_next, b2_fh_reg;
    logic [63:0]        b2_q_reg;
    psc_tag_t           b2_tag_reg;

    assign hs         = $signed(b1_q_reg) >>> 13;
    assign b2_aa_next = hs[31:0] * hs[31:0];
    assign b2_ab_next = hs[31:0] * hs[63:32];
    assign b2_fl_next = $signed({1'b0, b1_q_reg[31:0]}) * p8;
    assign b2_fh_next = b1_q_reg[63:32] * p8_w;

    // back stage 3
    logic signed [63:0] fl_w;
    logic signed [63:0] fsum;
    logic [63:0]        b3_h2_next, b3_h2_reg;
    logic signed [63:0] b3_f_reg;
    logic [63:0]        b3_q_reg;
    psc_tag_t           b3_tag_reg;

    assign b3_h2_next = b2_aa_reg + {b2_ab_reg[30:0], 33'b0};
    assign fl_w       = b2_fl_reg;
    assign fsum       = fl_w + $signed({b2_fh_reg, 32'b0});

    // back stage 4: p9 partial products
    logic signed [48:0] b4_el_next, b4_el_reg;
    logic [31:0]        b4_eh_next, b4_eh_reg;
    logic signed [63:0] b4_f_reg;
    logic [63:0]        b4_q_reg;
    psc_tag_t           b4_tag_reg;

    assign b4_el_next = $signed({1'b0, b3_h2_reg[31:0]}) * p9;
    assign b4_eh_next = b3_h2_reg[63:32] * p9_w;

    // back stage 5
    logic signed [63:0] el_w;
    logic signed [63:0] esum;
    logic signed [63:0] b5_s_next, b5_s_reg;
    psc_tag_t           b5_tag_reg;

    assign el_w      = b4_el_reg;
    assign esum      = el_w + $signed({b4_eh_reg, 32'b0});
    assign b5_s_next = $signed(b4_q_reg) + (esum >>> 25) + b4_f_reg;

    // output stage
    logic signed [63:0] pv;
    logic [31:0]        pres_next;

    assign pv = (b5_s_reg >>> 8) + (p7 <<< 4);

    always_comb
    begin
        if (b5_tag_reg.invalid || pv[63])
        begin
            pres_next = '0;
        end
        else if (pv[62:32] != 31'd0)
        begin
            pres_next = 32'hffff_ffff;
        end
        else
        begin
            pres_next = pv[31:0];
        end
    end

    logic signed [15:0] temp_reg;
    logic [31:0]        pres_reg;
    logic               inv_reg;

    always_ff @(posedge clk)
    begin
        b1_q_reg   <= b1_q_next;
        b1_tag_reg <= div_tag;

        b2_aa_reg  <= b2_aa_next;
        b2_ab_reg  <= b2_ab_next;
        b2_fl_reg  <= b2_fl_next;
        b2_fh_reg  <= b2_fh_next;
        b2_q_reg   <= b1_q_reg;
        b2_tag_reg <= b1_tag_reg;

        b3_h2_reg  <= b3_h2_next;
        b3_f_reg   <= fsum >>> 19;
        b3_q_reg   <= b2_q_reg;
        b3_tag_reg <= b2_tag_reg;

        b4_el_reg  <= b4_el_next;
        b4_eh_reg  <= b4_eh_next;
        b4_f_reg   <= b3_f_reg;
        b4_q_reg   <= b3_q_reg;
        b4_tag_reg <= b3_tag_reg;

        b5_s_reg   <= b5_s_next;
        b5_tag_reg <= b4_tag_reg;

        temp_reg   <= b5_tag_reg.tc;
        pres_reg   <= pres_next;
        inv_reg    <= b5_tag_reg.invalid;
    end

    assign done                     = done_reg;
    assign temperature_centidegrees = temp_reg;
    assign pressure_q24_8           = pres_reg;
    assign pressure_invalid         = inv_reg;

    // checks
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && pressure_invalid |-> pressure_q24_8 == 32'd0)
        else $error("invalid pressure result is not zero");

    a_request_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##32 done)
        else $error("request produced no result");

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        fv_reg[FRONT_STAGES-1] |-> ##16 div_valid)
        else $error("divider lost a request");

endmodule
